FILE: hdl/dpcbc_pkg.sv
// DES tables, configuration register codes and round functions for the PCBC cipher core.
package dpcbc_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_KEY     = 2'd0;
  localparam logic [1:0] CFG_IV      = 2'd1;
  localparam logic [1:0] CFG_DECRYPT = 2'd2;

  localparam int Rounds     = 16;
  localparam int SubkeyBits = 48;

  typedef logic [Rounds-1:0][SubkeyBits-1:0] subkeys_t;

  // Table entries number bits from 1 at the most significant end
  localparam logic [6:0] IP_TAB [64] = '{
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
    7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7};

  localparam logic [6:0] FP_TAB [64] = '{
    7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
    7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
    7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
    7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
    7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
    7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
    7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
    7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25};

  localparam logic [5:0] E_TAB [48] = '{
    6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,
    6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
    6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13,
    6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
    6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
    6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
    6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1};

  localparam logic [5:0] P_TAB [32] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25};

  localparam logic [6:0] PC1_TAB [56] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
    7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
    7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
    7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
    7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
    7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
    7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4};

  localparam logic [5:0] PC2_TAB [48] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
    6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
    6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
    6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
    6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32};

  // Left rotation per round: a set bit means two places, clear means one
  localparam logic [Rounds-1:0] ROT2_TAB = 16'b0111_1110_1111_1100;

  // S-boxes, indexed by {row, col}
  localparam logic [3:0] S_TAB [8][64] = '{
    '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
      4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
      4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
      4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
    '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
      4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
      4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
      4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
    '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
      4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
      4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
      4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
    '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
      4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
      4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
      4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
    '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
      4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
      4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
      4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
    '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
      4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
      4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
      4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
    '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
      4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
      4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
      4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
    '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
      4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
      4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
      4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}};

  // Zero the bytes past the valid count; zero count clears all, 8 or more keeps all
  function automatic logic [63:0] mask_block(logic [63:0] blk, logic [3:0] nbytes);
    logic [63:0] r;
    r = blk;
    for (int j = 0; j < 8; j++) begin
      if (nbytes <= 4'(j)) r[63-8*j -: 8] = 8'h00;
    end
    return r;
  endfunction

  function automatic logic [63:0] perm_ip(logic [63:0] x);
    logic [63:0] r;
    logic [5:0]  pos;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      pos = 6'(7'd64 - IP_TAB[i]);
      r[63-i] = x[pos];
    end
    return r;
  endfunction

  function automatic logic [63:0] perm_fp(logic [63:0] x);
    logic [63:0] r;
    logic [5:0]  pos;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      pos = 6'(7'd64 - FP_TAB[i]);
      r[63-i] = x[pos];
    end
    return r;
  endfunction

  // Round function: expand, mix key, substitute, permute
  function automatic logic [31:0] feistel(logic [31:0] rh, logic [47:0] sk);
    logic [47:0] x;
    logic [31:0] s;
    logic [31:0] r;
    logic [5:0]  b;
    logic [4:0]  pos;
    x = '0;
    for (int i = 0; i < 48; i++) begin
      pos = 5'(6'd32 - E_TAB[i]);
      x[47-i] = rh[pos];
    end
    x = x ^ sk;
    s = '0;
    for (int n = 0; n < 8; n++) begin
      b = x[47-6*n -: 6];
      s[31-4*n -: 4] = S_TAB[n][{b[5], b[0], b[4:1]}];
    end
    r = '0;
    for (int i = 0; i < 32; i++) begin
      pos = 5'(6'd32 - P_TAB[i]);
      r[31-i] = s[pos];
    end
    return r;
  endfunction

  // Key schedule: PC-1, per-round rotations, PC-2
  function automatic subkeys_t key_schedule(logic [63:0] key);
    logic [55:0] cd;
    logic [27:0] c;
    logic [27:0] d;
    logic [55:0] cat;
    logic [5:0]  pos;
    subkeys_t    sk;
    cd = '0;
    for (int i = 0; i < 56; i++) begin
      pos = 6'(7'd64 - PC1_TAB[i]);
      cd[55-i] = key[pos];
    end
    c  = cd[55:28];
    d  = cd[27:0];
    sk = '0;
    for (int rnd = 0; rnd < Rounds; rnd++) begin
      if (ROT2_TAB[rnd]) begin
        c = {c[25:0], c[27:26]};
        d = {d[25:0], d[27:26]};
      end else begin
        c = {c[26:0], c[27]};
        d = {d[26:0], d[27]};
      end
      cat = {c, d};
      for (int i = 0; i < 48; i++) begin
        pos = 6'(6'd56 - PC2_TAB[i]);
        sk[rnd][47-i] = cat[pos];
      end
    end
    return sk;
  endfunction

  // Full 16-round DES, subkeys taken in reverse order for decryption
  function automatic logic [63:0] des_block(logic [63:0] blk, subkeys_t sk, logic backward);
    logic [63:0] v;
    logic [31:0] l;
    logic [31:0] r;
    logic [31:0] t;
    v = perm_ip(blk);
    l = v[63:32];
    r = v[31:0];
    for (int i = 0; i < Rounds; i++) begin
      t = l ^ feistel(r, backward ? sk[Rounds-1-i] : sk[i]);
      l = r;
      r = t;
    end
    return perm_fp({r, l});
  endfunction

endpackage

FILE: hdl/des_pcbc_block_cipher_core.sv
// DES cipher core in PCBC mode: input register, unrolled 16 rounds, result register.
// An accepted item waits in the input register, then moves into the result register.
// Throughput: one item per cycle unless out_stall holds the result register; the 16
// unrolled DES rounds and chain update sit combinationally between those registers.
// Reset: rst_n synchronous active low; clears both valid flags, the chain value
// and all configuration registers (key, IV, mode) to zero.
module des_pcbc_block_cipher_core (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_data_block,
  input  logic [3:0]  in_valid_bytes,
  input  logic        in_first_block,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_block,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import dpcbc_pkg::*;

  logic [63:0] key_r;
  logic [63:0] iv_r;
  logic        decrypt_r;

  logic        s1_valid_r;
  logic [63:0] s1_blk_r;
  logic        s1_first_r;

  logic        out_valid_r;
  logic [63:0] out_block_r;
  logic [63:0] chain_r;

  logic        in_accept;
  logic        out_load;
  logic        s1_adv;
  logic [63:0] chain_sel;
  logic [63:0] des_in;
  logic [63:0] des_out;
  logic [63:0] res_nxt;
  logic [63:0] chain_nxt;
  subkeys_t    subkeys;

  // Handshake control
  assign out_load  = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && out_load;
  assign in_stall  = s1_valid_r && !out_load;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r     <= '0;
      iv_r      <= '0;
      decrypt_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KEY:     key_r     <= cfg_data;
        CFG_IV:      iv_r      <= cfg_data;
        CFG_DECRYPT: decrypt_r <= cfg_data[0];
        default:     ;
      endcase
    end
  end

  // Input register: capture the masked block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_blk_r   <= mask_block(in_data_block, in_valid_bytes);
      s1_first_r <= in_first_block;
    end
  end

  // Cipher datapath with PCBC chaining
  always_comb begin
    subkeys   = key_schedule(key_r);
    chain_sel = s1_first_r ? iv_r : chain_r;
    des_in    = decrypt_r ? s1_blk_r : (s1_blk_r ^ chain_sel);
    des_out   = des_block(des_in, subkeys, decrypt_r);
    res_nxt   = decrypt_r ? (des_out ^ chain_sel) : des_out;
    chain_nxt = s1_blk_r ^ res_nxt;
  end

  // Advance chain value as each item leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= '0;
    end else if (s1_adv) begin
      chain_r <= chain_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_block_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_block = out_block_r;

`ifndef ASSERT_OFF
  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("result register empty after item advanced");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty input register");

  a_free_out_advances: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_stall |-> s1_adv && !in_stall)
    else $error("item held while result side is free");

  a_chain_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(chain_r))
    else $error("chain value changed without an item");
`endif

endmodule
